/* hdl/eam_pkg.sv */
`default_nettype none
package eam_pkg;

  localparam int MATRIX_SIZE  = 3;
  localparam int ATAN_ENTRIES = 24;

  // Lane order of the three rotators.
  localparam int AX_ROLL  = 0;
  localparam int AX_PITCH = 1;
  localparam int AX_YAW   = 2;

  // Angles in Q.30 radians, carried in 35 bits to cover the widened input.
  localparam logic signed [34:0] ANG_PI      = 35'sd3373259426;
  localparam logic signed [34:0] ANG_TWO_PI  = 35'sd6746518852;
  localparam logic signed [34:0] ANG_HALF_PI = 35'sd1686629713;

  localparam logic signed [15:0] ENTRY_MAX = 16'sd16384;

  // Numerator of the gain computation, two to the 62nd.
  localparam logic [63:0] GAIN_NUM = 64'h4000_0000_0000_0000;

  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } eam_angles_t;

  typedef struct packed {
    logic signed [15:0] entry_r0c0;
    logic signed [15:0] entry_r0c1;
    logic signed [15:0] entry_r0c2;
    logic signed [15:0] entry_r1c0;
    logic signed [15:0] entry_r1c1;
    logic signed [15:0] entry_r1c2;
    logic signed [15:0] entry_r2c0;
    logic signed [15:0] entry_r2c1;
    logic signed [15:0] entry_r2c2;
  } eam_matrix_t;

  // One rotator: vector, residual angle and the half-turn fold flag.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [32:0] z;
    logic               flip;
  } lane_t;

  typedef lane_t [MATRIX_SIZE-1:0] lanes_t;

  // Denominator of the rotator gain for n stages; used at elaboration only.
  function automatic logic [63:0] eam_gain_p(input int n);
    logic [63:0] p;
    p = 64'd1 << 30;
    for (int i = 0; i < ATAN_ENTRIES; i++) begin
      if (i < n) begin
        p = p + (p >> (2 * i));
      end
    end
    return p;
  endfunction

  // Integer square root; used at elaboration only.
  function automatic logic [63:0] eam_isqrt(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = n;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Q.30 product, rounded half up.
  function automatic logic signed [31:0] eam_mul_q30(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    p = p + 64'sd536870912;
    return p[61:30];
  endfunction

  // Q.30 sum to Q2.14, rounded and clamped to plus or minus one.
  function automatic logic signed [15:0] eam_to_entry(input logic signed [33:0] v);
    logic signed [33:0] t;
    logic signed [17:0] e;
    t = v + 34'sd32768;
    e = t[33:16];
    if (e > 18'(ENTRY_MAX)) begin
      return ENTRY_MAX;
    end else if (e < -18'(ENTRY_MAX)) begin
      return -ENTRY_MAX;
    end
    return e[15:0];
  endfunction

endpackage
`default_nettype wire

/* hdl/eam_if.sv */
`default_nettype none
interface eam_in_if import eam_pkg::*; ();
  logic        valid;
  logic        ready;
  eam_angles_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface eam_out_if import eam_pkg::*; ();
  logic        valid;
  logic        ready;
  eam_matrix_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/eam_fold.sv */
`default_nettype none
module eam_fold import eam_pkg::*; #(
  parameter logic signed [31:0] GAIN = 32'sd0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  eam_angles_t in_data,
  output logic        out_valid,
  output lanes_t      out_lanes
);

  logic signed [15:0] ang      [MATRIX_SIZE];
  logic signed [32:0] turn_nxt [MATRIX_SIZE];
  logic signed [32:0] turn_r   [MATRIX_SIZE];
  lanes_t             lanes_nxt;
  lanes_t             lanes_r;
  logic               valid1_r;
  logic               valid2_r;

  always_comb begin
    ang[AX_ROLL]  = in_data.roll_angle;
    ang[AX_PITCH] = in_data.pitch_angle;
    ang[AX_YAW]   = in_data.yaw_angle;
  end

  // First step: scale to Q.30 and take off one full turn if needed.
  always_comb begin
    logic signed [34:0] a;
    for (int i = 0; i < MATRIX_SIZE; i++) begin
      a = {ang[i][15], ang[i], 18'b0};
      if (a > ANG_PI) begin
        a = a - ANG_TWO_PI;
      end else if (a < -ANG_PI) begin
        a = a + ANG_TWO_PI;
      end
      turn_nxt[i] = a[32:0];
    end
  end

  // Second step: fold into the right half plane; the flag negates sine and cosine.
  always_comb begin
    logic signed [34:0] b;
    for (int i = 0; i < MATRIX_SIZE; i++) begin
      b = 35'(turn_r[i]);
      lanes_nxt[i].flip = 1'b0;
      if (b > ANG_HALF_PI) begin
        b = b - ANG_PI;
        lanes_nxt[i].flip = 1'b1;
      end else if (b < -ANG_HALF_PI) begin
        b = b + ANG_PI;
        lanes_nxt[i].flip = 1'b1;
      end
      lanes_nxt[i].x = GAIN;
      lanes_nxt[i].y = '0;
      lanes_nxt[i].z = b[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else if (adv) begin
      valid1_r <= in_valid;
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      turn_r  <= turn_nxt;
      lanes_r <= lanes_nxt;
    end
  end

  assign out_valid = valid2_r;
  assign out_lanes = lanes_r;

  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid2_r |-> ($signed(lanes_r[AX_ROLL].z) <= ANG_HALF_PI &&
                  $signed(lanes_r[AX_ROLL].z) >= -ANG_HALF_PI &&
                  $signed(lanes_r[AX_PITCH].z) <= ANG_HALF_PI &&
                  $signed(lanes_r[AX_PITCH].z) >= -ANG_HALF_PI &&
                  $signed(lanes_r[AX_YAW].z) <= ANG_HALF_PI &&
                  $signed(lanes_r[AX_YAW].z) >= -ANG_HALF_PI))
    else $error("folded angle outside the quarter turn");

endmodule
`default_nettype wire

/* hdl/eam_cell.sv */
`default_nettype none
module eam_cell import eam_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  logic   in_valid,
  input  lanes_t in_lanes,
  output logic   out_valid,
  output lanes_t out_lanes
);

  logic signed [32:0] ang;
  lanes_t             lanes_nxt;
  lanes_t             lanes_r;
  logic               valid_r;

  assign ang = signed'(33'(ATAN_Q30[STAGE]));

  // One micro-rotation per lane, direction set by the sign of the residual angle.
  always_comb begin
    for (int i = 0; i < MATRIX_SIZE; i++) begin
      lanes_nxt[i] = in_lanes[i];
      if (!in_lanes[i].z[32]) begin
        lanes_nxt[i].x = $signed(in_lanes[i].x) - ($signed(in_lanes[i].y) >>> STAGE);
        lanes_nxt[i].y = $signed(in_lanes[i].y) + ($signed(in_lanes[i].x) >>> STAGE);
        lanes_nxt[i].z = $signed(in_lanes[i].z) - ang;
      end else begin
        lanes_nxt[i].x = $signed(in_lanes[i].x) + ($signed(in_lanes[i].y) >>> STAGE);
        lanes_nxt[i].y = $signed(in_lanes[i].y) - ($signed(in_lanes[i].x) >>> STAGE);
        lanes_nxt[i].z = $signed(in_lanes[i].z) + ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lanes_r <= lanes_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_lanes = lanes_r;

endmodule
`default_nettype wire

/* hdl/eam_prod.sv */
`default_nettype none
module eam_prod import eam_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         adv,
  input  logic         in_valid,
  input  lanes_t       in_lanes,
  output logic         tail_valid,
  eam_out_if.source    out_chan
);

  logic signed [31:0] sin_r [MATRIX_SIZE];
  logic signed [31:0] cos_r [MATRIX_SIZE];
  logic               v0_r;
  logic               v1_r;
  logic               v2_r;

  // First product level.
  logic signed [31:0] cycp_r, cysp_r, sycp_r, sysp_r, sycr_r, cycr_r, crsp_r, crcp_r;
  logic signed [31:0] sysr_r, cysr_r, sp1_r, cp1_r, sr1_r;

  // Second product level and the pass-through terms.
  logic signed [31:0] sysrsp_r, sysrcp_r, cysrsp_r, cysrcp_r;
  logic signed [31:0] cycp2_r, cysp2_r, sycp2_r, sysp2_r, sycr2_r, cycr2_r;
  logic signed [31:0] crsp2_r, crcp2_r, sr2_r;

  logic        out_valid_r;
  eam_matrix_t out_data_r;
  eam_matrix_t out_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < MATRIX_SIZE; i++) begin
        sin_r[i] <= in_lanes[i].flip ? -$signed(in_lanes[i].y) : in_lanes[i].y;
        cos_r[i] <= in_lanes[i].flip ? -$signed(in_lanes[i].x) : in_lanes[i].x;
      end

      cycp_r <= eam_mul_q30(cos_r[AX_YAW], cos_r[AX_PITCH]);
      cysp_r <= eam_mul_q30(cos_r[AX_YAW], sin_r[AX_PITCH]);
      sycp_r <= eam_mul_q30(sin_r[AX_YAW], cos_r[AX_PITCH]);
      sysp_r <= eam_mul_q30(sin_r[AX_YAW], sin_r[AX_PITCH]);
      sycr_r <= eam_mul_q30(sin_r[AX_YAW], cos_r[AX_ROLL]);
      cycr_r <= eam_mul_q30(cos_r[AX_YAW], cos_r[AX_ROLL]);
      crsp_r <= eam_mul_q30(cos_r[AX_ROLL], sin_r[AX_PITCH]);
      crcp_r <= eam_mul_q30(cos_r[AX_ROLL], cos_r[AX_PITCH]);
      sysr_r <= eam_mul_q30(sin_r[AX_YAW], sin_r[AX_ROLL]);
      cysr_r <= eam_mul_q30(cos_r[AX_YAW], sin_r[AX_ROLL]);
      sp1_r  <= sin_r[AX_PITCH];
      cp1_r  <= cos_r[AX_PITCH];
      sr1_r  <= sin_r[AX_ROLL];

      // Three-factor terms round the first pair before the second multiply.
      sysrsp_r <= eam_mul_q30(sysr_r, sp1_r);
      sysrcp_r <= eam_mul_q30(sysr_r, cp1_r);
      cysrsp_r <= eam_mul_q30(cysr_r, sp1_r);
      cysrcp_r <= eam_mul_q30(cysr_r, cp1_r);
      cycp2_r  <= cycp_r;
      cysp2_r  <= cysp_r;
      sycp2_r  <= sycp_r;
      sysp2_r  <= sysp_r;
      sycr2_r  <= sycr_r;
      cycr2_r  <= cycr_r;
      crsp2_r  <= crsp_r;
      crcp2_r  <= crcp_r;
      sr2_r    <= sr1_r;
    end
  end

  always_comb begin
    out_data_nxt.entry_r0c0 = eam_to_entry(34'(cycp2_r) + 34'(sysrsp_r));
    out_data_nxt.entry_r0c1 = eam_to_entry(34'(sycr2_r));
    out_data_nxt.entry_r0c2 = eam_to_entry(-34'(cysp2_r) + 34'(sysrcp_r));
    out_data_nxt.entry_r1c0 = eam_to_entry(-34'(sycp2_r) + 34'(cysrsp_r));
    out_data_nxt.entry_r1c1 = eam_to_entry(34'(cycr2_r));
    out_data_nxt.entry_r1c2 = eam_to_entry(34'(sysp2_r) + 34'(cysrcp_r));
    out_data_nxt.entry_r2c0 = eam_to_entry(34'(crsp2_r));
    out_data_nxt.entry_r2c1 = eam_to_entry(-34'(sr2_r));
    out_data_nxt.entry_r2c2 = eam_to_entry(34'(crcp2_r));
  end

  // The output register loads whenever it is empty or its request is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_chan.ready) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_chan.ready) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign tail_valid     = v2_r;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule
`default_nettype wire

/* hdl/euler_angles_to_rotation_matrix.sv */
`default_nettype none
// Turns roll, pitch and yaw (signed Q4.12 radians) into the nine entries of the
// 3x3 attitude matrix (signed Q2.14, rounded and clamped to plus or minus one).
// The block is a fixed pipeline: angle reduction (a full-turn fold, then a half-turn
// fold), one rotation cell per CORDIC stage for all three angles in parallel, a
// sign-fold stage, two product levels and the output register (CORDIC_STAGES is
// capped at 24). A new request is taken every cycle while ready is high; when the
// output is held, the pipeline keeps moving until the second product level holds a
// request, and only then is ready dropped.
module euler_angles_to_rotation_matrix import eam_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  eam_in_if.sink    in_chan,
  eam_out_if.source out_chan
);

  localparam int NUM_STAGES =
    (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

  // Rotator gain, worked out at elaboration.
  localparam logic [63:0] GAIN_P  = eam_gain_p(NUM_STAGES);
  localparam logic [63:0] GAIN_Q  = GAIN_NUM / GAIN_P;
  localparam logic [63:0] GAIN_R  = GAIN_NUM % GAIN_P;
  localparam logic [63:0] GAIN_K2 = (GAIN_Q << 28) + ((GAIN_R << 28) / GAIN_P);
  localparam logic [63:0] GAIN_K  = eam_isqrt(GAIN_K2);

  logic   adv;
  logic   tail_valid;
  logic   chain_valid [NUM_STAGES+1];
  lanes_t chain_lanes [NUM_STAGES+1];

  assign adv           = !out_chan.valid || out_chan.ready || !tail_valid;
  assign in_chan.ready = adv;

  eam_fold #(
    .GAIN (32'(GAIN_K))
  ) u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_chan.valid),
    .in_data   (in_chan.data),
    .out_valid (chain_valid[0]),
    .out_lanes (chain_lanes[0])
  );

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
    eam_cell #(
      .STAGE (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (chain_valid[g]),
      .in_lanes  (chain_lanes[g]),
      .out_valid (chain_valid[g+1]),
      .out_lanes (chain_lanes[g+1])
    );
  end

  eam_prod u_prod (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (chain_valid[NUM_STAGES]),
    .in_lanes   (chain_lanes[NUM_STAGES]),
    .tail_valid (tail_valid),
    .out_chan   (out_chan)
  );

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready && tail_valid) |-> !in_chan.ready)
    else $error("input taken while the pipeline is full and the output is held");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.data.entry_r0c0 <= ENTRY_MAX &&
                        out_chan.data.entry_r0c0 >= -ENTRY_MAX &&
                        out_chan.data.entry_r1c1 <= ENTRY_MAX &&
                        out_chan.data.entry_r1c1 >= -ENTRY_MAX &&
                        out_chan.data.entry_r2c2 <= ENTRY_MAX &&
                        out_chan.data.entry_r2c2 >= -ENTRY_MAX))
    else $error("matrix entry beyond plus or minus one");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire
